>>> rtl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg: shared types and codes of the blink-code status display
// Item and result payloads, phase enum, mode and pattern codes, thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbc_pkg;

    // Default timer width, used as the default of the top level's TIMER_BITS
    localparam int TIMER_BITS_DEF = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_ON  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_OFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT  = 2'd2;

    localparam logic [CFG_DATA_W-1:0] LED_ON_RST  = 16'd150;
    localparam logic [CFG_DATA_W-1:0] LED_OFF_RST = 16'd300;
    localparam logic [CFG_DATA_W-1:0] REPEAT_RST  = 16'd2000;

    // Display modes
    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_BATT = 3'd1;
    localparam logic [2:0] MODE_SD   = 3'd2;
    localparam logic [2:0] MODE_REC  = 3'd3;
    localparam logic [2:0] MODE_GPS  = 3'd4;

    // Status patterns: off, on, then one to four blinks
    localparam logic [2:0] PAT_OFF    = 3'd0;
    localparam logic [2:0] PAT_ON     = 3'd1;
    localparam logic [2:0] PAT_BLINK1 = 3'd2;
    localparam logic [2:0] PAT_BLINK2 = 3'd3;
    localparam logic [2:0] PAT_BLINK3 = 3'd4;
    localparam logic [2:0] PAT_BLINK4 = 3'd5;

    // Battery thresholds in tenths of a percent
    localparam logic [9:0] BATT_LVL4 = 10'd800;
    localparam logic [9:0] BATT_LVL3 = 10'd600;
    localparam logic [9:0] BATT_LVL2 = 10'd300;
    localparam logic [9:0] BATT_LVL1 = 10'd100;

    typedef enum logic [1:0] {
        PH_START,
        PH_MODE,
        PH_STATUS,
        PH_WAIT
    } t_phase;

    typedef struct packed {
        logic        advance_mode;
        logic        restart;
        logic        rec_running;
        logic [1:0]  gps_state;
        logic [9:0]  battery_level;
        logic        sd_ok;
        logic [21:0] sd_free;
        logic [21:0] sd_total;
    } t_item;

    typedef struct packed {
        logic       led1_on;
        logic       led2_on;
        logic [2:0] display_mode;
        logic [2:0] status_pattern;
    } t_result;

    // Status level proposal: keep means leave the pattern alone
    typedef struct packed {
        logic       keep;
        logic [2:0] pattern;
    } t_status;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] led_on_ms;
        logic [CFG_DATA_W-1:0] led_off_ms;
        logic [CFG_DATA_W-1:0] repeat_ms;
    } t_cfg;

endpackage

>>> rtl/lbc_if.sv
// ----------------------------------------------------------------------------
// lbc_if: valid/ready channels of the blink-code status display
// Tick item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lbc_item_if;
    import lbc_pkg::*;
    logic  valid;
    logic  ready;
    t_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lbc_result_if;
    import lbc_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lbc_cfg_if;
    import lbc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/lbc_status.sv
// ----------------------------------------------------------------------------
// lbc_status: status level evaluation
// Maps the live status values of the current mode to a blink pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbc_status (
    input  logic [2:0]     i_mode,
    input  lbc_pkg::t_item i_item,
    output lbc_pkg::t_status o_status
);
    import lbc_pkg::*;

    logic [23:0] free_x4;
    logic [23:0] total_x3;
    logic [22:0] free_x2;
    logic [23:0] total_ext;

    // Scale free and total so the ratio tests are plain compares
    assign free_x4   = {i_item.sd_free, 2'b00};
    assign free_x2   = {i_item.sd_free, 1'b0};
    assign total_ext = {2'b00, i_item.sd_total};
    assign total_x3  = total_ext + {1'b0, i_item.sd_total, 1'b0};

    // Pick the pattern for the active mode
    always_comb begin
        o_status.keep    = 1'b0;
        o_status.pattern = PAT_OFF;
        unique case (i_mode)
            MODE_BATT: begin
                priority if (i_item.battery_level > BATT_LVL4) o_status.pattern = PAT_BLINK4;
                else if (i_item.battery_level > BATT_LVL3)     o_status.pattern = PAT_BLINK3;
                else if (i_item.battery_level > BATT_LVL2)     o_status.pattern = PAT_BLINK2;
                else if (i_item.battery_level > BATT_LVL1)     o_status.pattern = PAT_BLINK1;
                else                                           o_status.pattern = PAT_OFF;
            end
            MODE_SD: begin
                // Invalid or empty card: leave the previous level standing
                if (!i_item.sd_ok || i_item.sd_total == '0) begin
                    o_status.keep = 1'b1;
                end else begin
                    priority if (free_x4 > total_x3)               o_status.pattern = PAT_BLINK4;
                    else if (free_x2 > total_ext[22:0])            o_status.pattern = PAT_BLINK3;
                    else if (free_x4 > total_ext)                  o_status.pattern = PAT_BLINK2;
                    else                                           o_status.pattern = PAT_BLINK1;
                end
            end
            MODE_REC: begin
                o_status.pattern = i_item.rec_running ? PAT_ON : PAT_OFF;
            end
            MODE_GPS: begin
                o_status.pattern = {1'b0, i_item.gps_state} + PAT_BLINK1;
            end
            default: begin
                o_status.pattern = PAT_OFF;
            end
        endcase
    end

endmodule

>>> rtl/lbc_seq.sv
// ----------------------------------------------------------------------------
// lbc_seq: blink sequencer
// Mode register, phase machine, blink counters, timer and LED registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbc_seq #(
    parameter int TIMER_BITS = lbc_pkg::TIMER_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  lbc_pkg::t_item    i_item,
    input  lbc_pkg::t_status  i_status,
    input  lbc_pkg::t_cfg     i_cfg,
    output logic [2:0]        o_next_mode,
    output lbc_pkg::t_result  o_result
);
    import lbc_pkg::*;

    localparam int LW = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;

    // Clamp a period to the timer range
    function automatic logic [TIMER_BITS-1:0] load_timer(input logic [CFG_DATA_W-1:0] v);
        logic [LW-1:0] v_ext;
        logic [LW-1:0] top_ext;
        v_ext   = LW'(v);
        top_ext = LW'({TIMER_BITS{1'b1}});
        return (v_ext > top_ext) ? TIMER_BITS'(top_ext) : TIMER_BITS'(v_ext);
    endfunction

    t_phase                r_phase, n_phase;
    logic [2:0]            r_mode, n_mode;
    logic [TIMER_BITS-1:0] r_timer, n_timer;
    logic [2:0]            r_mdone, n_mdone;
    logic [2:0]            r_sdone, n_sdone;
    logic [2:0]            r_smax;
    logic [2:0]            r_pattern;
    logic                  r_led1, n_led1;
    logic                  r_led2, n_led2;
    logic                  r_rec_seen;

    t_phase                ph0;
    logic                  do_refresh;
    logic [2:0]            pat1;
    logic [2:0]            max1;
    logic                  led2_1;
    logic [TIMER_BITS-1:0] t1;
    logic                  alarm;
    logic                  mode_more;
    logic                  stat_go;
    logic                  stat_more;

    // Step the mode on advance; any pulse restarts the sequence
    always_comb begin
        if (i_item.advance_mode) begin
            priority if (r_mode < MODE_GPS) n_mode = r_mode + 3'd1;
            else if (r_mode == MODE_GPS)    n_mode = MODE_IDLE;
            else                            n_mode = MODE_GPS;
        end else begin
            n_mode = r_mode;
        end
        ph0 = (i_item.advance_mode || i_item.restart) ? PH_START : r_phase;
    end

    assign o_next_mode = n_mode;

    // Apply a new pattern at sequence start or on a recording change
    always_comb begin
        do_refresh = (i_item.rec_running != r_rec_seen) || (ph0 == PH_START);
        pat1   = r_pattern;
        max1   = r_smax;
        led2_1 = r_led2;
        if (do_refresh && !i_status.keep && i_status.pattern != r_pattern) begin
            pat1 = i_status.pattern;
            if (i_status.pattern == PAT_OFF) begin
                max1   = 3'd0;
                led2_1 = 1'b0;
            end else if (i_status.pattern == PAT_ON) begin
                led2_1 = 1'b1;
            end else begin
                max1 = i_status.pattern - 3'd1;
            end
        end
    end

    // Count the timer down and flag expiry
    assign t1        = r_timer - TIMER_BITS'(r_timer != '0);
    assign alarm     = (t1 == '0);
    assign mode_more = (r_mdone < n_mode);
    assign stat_go   = (max1 != 3'd0) && (pat1 != PAT_OFF);
    assign stat_more = (r_sdone < max1);

    // Next phase
    always_comb begin
        n_phase = ph0;
        unique case (ph0)
            PH_START: begin
                n_phase = PH_MODE;
            end
            PH_WAIT: begin
                if (alarm) n_phase = PH_START;
            end
            PH_MODE: begin
                if (alarm && !r_led1 && !mode_more) begin
                    n_phase = stat_go ? PH_STATUS : PH_WAIT;
                end
            end
            PH_STATUS: begin
                if (alarm && pat1 != PAT_OFF && pat1 != PAT_ON && !led2_1 && !stat_more) begin
                    n_phase = PH_WAIT;
                end
            end
        endcase
    end

    // LEDs, counters and timer loads per phase
    always_comb begin
        n_timer = t1;
        n_led1  = r_led1;
        n_led2  = led2_1;
        n_mdone = r_mdone;
        n_sdone = r_sdone;
        unique case (ph0)
            PH_START: begin
                n_mdone = 3'd0;
                n_sdone = 3'd0;
                if (n_mode != MODE_IDLE) begin
                    n_led1  = 1'b1;
                    n_mdone = 3'd1;
                    n_timer = load_timer(i_cfg.led_on_ms);
                end
            end
            PH_WAIT: begin
                n_timer = t1;
            end
            PH_MODE: begin
                if (alarm) begin
                    priority if (r_led1) begin
                        n_led1  = 1'b0;
                        n_timer = load_timer(i_cfg.led_off_ms);
                    end else if (mode_more) begin
                        n_mdone = r_mdone + 3'd1;
                        n_led1  = 1'b1;
                        n_timer = load_timer(i_cfg.led_on_ms);
                    end else if (stat_go) begin
                        n_led2  = 1'b1;
                        n_sdone = r_sdone + 3'd1;
                        n_timer = load_timer(i_cfg.led_on_ms);
                    end else begin
                        n_timer = load_timer(i_cfg.repeat_ms);
                    end
                end
            end
            PH_STATUS: begin
                if (alarm) begin
                    priority if (pat1 == PAT_OFF) begin
                        n_led2 = 1'b0;
                    end else if (pat1 == PAT_ON) begin
                        n_led2 = 1'b1;
                    end else if (led2_1) begin
                        n_led2  = 1'b0;
                        n_timer = load_timer(i_cfg.led_off_ms);
                    end else if (stat_more) begin
                        n_sdone = r_sdone + 3'd1;
                        n_led2  = 1'b1;
                        n_timer = load_timer(i_cfg.led_on_ms);
                    end else begin
                        n_timer = load_timer(i_cfg.repeat_ms);
                    end
                end
            end
        endcase
    end

    // Commit one tick per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_START;
            r_mode     <= MODE_IDLE;
            r_timer    <= '0;
            r_mdone    <= 3'd0;
            r_sdone    <= 3'd0;
            r_smax     <= 3'd0;
            r_pattern  <= PAT_OFF;
            r_led1     <= 1'b0;
            r_led2     <= 1'b0;
            r_rec_seen <= 1'b0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_mode     <= n_mode;
            r_timer    <= n_timer;
            r_mdone    <= n_mdone;
            r_sdone    <= n_sdone;
            r_smax     <= max1;
            r_pattern  <= pat1;
            r_led1     <= n_led1;
            r_led2     <= n_led2;
            r_rec_seen <= i_item.rec_running;
        end
    end

    assign o_result.led1_on        = r_led1;
    assign o_result.led2_on        = r_led2;
    assign o_result.display_mode   = r_mode;
    assign o_result.status_pattern = r_pattern;

endmodule

>>> rtl/led_blink_code_status.sv
// Two-LED blink-code status display driven by a millisecond tick item. Each
// accepted item yields exactly one result with both LED levels, the display
// mode and the status pattern. One item is taken every clock cycle while the
// input register is empty or its item moves on; a result is valid once its
// item has passed the input register and then the sequencer state, which
// doubles as the result register. A stalled result holds only one item in
// the input register behind it. Periods are written on the configuration
// channel (index 0 on time, 1 off time, 2 pause), which is always ready.
// ----------------------------------------------------------------------------
// led_blink_code_status: blink-code status display top level
// Input register, configuration registers, status evaluation and sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module led_blink_code_status #(
    parameter int TIMER_BITS = lbc_pkg::TIMER_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lbc_item_if.sink      i_item,
    lbc_cfg_if.sink       i_cfg,
    lbc_result_if.source  o_result
);
    import lbc_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_cfg    r_cfg;
    logic    fire;
    logic [2:0] next_mode;
    t_status status;

    // Advance the stage when the result slot is free or being taken
    assign fire         = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || fire;
    assign i_cfg.ready  = 1'b1;

    // Hold the incoming item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in <= i_item.data;
        end
    end

    // Track the result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_on_ms  <= LED_ON_RST;
            r_cfg.led_off_ms <= LED_OFF_RST;
            r_cfg.repeat_ms  <= REPEAT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_LED_ON:  r_cfg.led_on_ms  <= i_cfg.data;
                CFG_LED_OFF: r_cfg.led_off_ms <= i_cfg.data;
                CFG_REPEAT:  r_cfg.repeat_ms  <= i_cfg.data;
                default:     r_cfg            <= r_cfg;
            endcase
        end
    end

    lbc_status u_status (
        .i_mode   (next_mode),
        .i_item   (r_in),
        .o_status (status)
    );

    lbc_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in),
        .i_status    (status),
        .i_cfg       (r_cfg),
        .o_next_mode (next_mode),
        .o_result    (o_result.data)
    );

    assign o_result.valid = r_out_valid;

`ifndef NO_ASSERTIONS
    // Pattern off always leaves the status LED dark
    a_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.data.status_pattern == PAT_OFF) |-> !o_result.data.led2_on)
        else $error("status LED lit with pattern off");

    // Pattern on always keeps the status LED lit
    a_on_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.data.status_pattern == PAT_ON) |-> o_result.data.led2_on)
        else $error("status LED dark with pattern on");

    // A full input stage behind a stalled result takes no new item
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_result.ready) |-> !i_item.ready)
        else $error("item taken while both stages are full");

    // Every tick processed shows up as a result next cycle
    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_result.valid)
        else $error("processed item produced no result");
`endif

endmodule
